// ===== rtl/core/usr_pkg.sv =====
// ----------------------------------------------------------------------------
// usr_pkg
// Shared types, register codes, reset values and decode helpers for the
// ultrasonic ranger with seven-segment display.
// ----------------------------------------------------------------------------
package usr_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TRIGGER_LENGTH = 3'd0,
    CFG_RETRY_HOLDOFF  = 3'd1,
    CFG_DIGIT_DWELL    = 3'd2,
    CFG_FRAME_PERIOD   = 3'd3,
    CFG_RANGE_SCALE    = 3'd4,
    CFG_RANGE_MINIMUM  = 3'd5,
    CFG_RANGE_MAXIMUM  = 3'd6
  } cfg_reg_e;

  localparam logic [15:0] TRIGGER_LENGTH_RST = 16'd20;
  localparam logic [23:0] RETRY_HOLDOFF_RST  = 24'd500000;
  localparam logic [15:0] DIGIT_DWELL_RST    = 16'd5000;
  localparam logic [23:0] FRAME_PERIOD_RST   = 24'd500000;
  localparam logic [9:0]  RANGE_SCALE_RST    = 10'd281;
  localparam logic [9:0]  RANGE_MINIMUM_RST  = 10'd5;
  localparam logic [9:0]  RANGE_MAXIMUM_RST  = 10'd200;

  typedef struct packed {
    logic echo_level;
    logic timer_advance;
  } in_item_t;

  typedef struct packed {
    logic       trigger_out;
    logic [7:0] segment_pattern;
    logic [3:0] digit_select_n;
    logic [9:0] range_value;
    logic       range_update;
  } out_item_t;

  typedef struct packed {
    cfg_reg_e    index;
    logic [23:0] value;
  } cfg_write_t;

  // Standard 0-9 segment patterns, bit0 = segment a
  function automatic logic [7:0] seg_decode(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h3F;
    endcase
    return pat;
  endfunction

  // Decimal digit idx of a 10-bit value. x/10 = (x*205)>>11 is exact below 1029.
  function automatic logic [3:0] range_digit(input logic [9:0] x, input logic [2:0] idx);
    logic [17:0] p1;
    logic [6:0]  q1;
    logic [14:0] p2;
    logic [3:0]  q2;
    logic        q3;
    logic [9:0]  r0;
    logic [6:0]  r1;
    logic [3:0]  r2;
    logic [3:0]  dig;
    p1  = 18'(x) * 18'd205;
    q1  = p1[17:11];
    p2  = 15'(q1) * 15'd205;
    q2  = p2[14:11];
    q3  = (q2 >= 4'd10);
    r0  = x - 10'(q1) * 10'd10;
    r1  = q1 - 7'(q2) * 7'd10;
    r2  = q3 ? (q2 - 4'd10) : q2;
    unique case (idx)
      3'd0:    dig = r0[3:0];
      3'd1:    dig = r1[3:0];
      3'd2:    dig = r2;
      3'd3:    dig = {3'b000, q3};
      default: dig = 4'd0;
    endcase
    return dig;
  endfunction

endpackage

// ===== rtl/core/usr_stream_if.sv =====
// ----------------------------------------------------------------------------
// usr_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface usr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ultrasonic_ranger_seven_seg.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_ranger_seven_seg
// Ultrasonic echo ranger with a multiplexed four-digit seven-segment display.
// The result of a tick is registered: it is loaded into the output register
// at the edge of its transfer.
// Throughput: one tick per cycle, limited only by the single output register.
// Reset: control state and configuration go to defaults, output is empty.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_seven_seg
  import usr_pkg::*;
#(
  parameter int DIGIT_COUNT = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  usr_stream_if.sink   cfg_i,
  usr_stream_if.sink   in_i,
  usr_stream_if.source out_o
);

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_RISE = 3'd2,
    PH_FALL = 3'd3,
    PH_HOLD = 3'd4
  } phase_e;

  // configuration
  logic [15:0] trig_len_q;
  logic [23:0] retry_q;
  logic [15:0] dwell_cfg_q;
  logic [23:0] period_q;
  logic [9:0]  scale_q;
  logic [9:0]  min_q;
  logic [9:0]  max_q;

  // state
  phase_e           phase_q, phase_d;
  logic [23:0]      ph_ticks_q, ph_ticks_d;
  logic [7:0]       timer_q, timer_d;
  logic [7:0]       rise_q, rise_d;
  logic [9:0]       held_q, held_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      dwell_q, dwell_d;
  logic [23:0]      frame_q, frame_d;

  // output register
  logic             out_valid_q;
  logic             out_trig_q;
  logic [3:0]       out_sel_q;
  logic [9:0]       out_range_q;
  logic             out_upd_q;
  logic [IDX_W-1:0] out_idx_q;

  logic        in_fire;
  logic        cfg_fire;
  logic        update;
  logic        cleared;
  logic [7:0]  width;
  logic [17:0] product;
  logic [9:0]  range_raw;
  logic [9:0]  range_clamp;
  logic [3:0]  sel;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;
  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign in_fire     = in_i.valid & in_i.ready;

  assign width       = timer_q - rise_q;
  assign product     = 18'(width) * 18'(scale_q);
  assign range_raw   = product[17:8];

  always_comb begin
    range_clamp = (range_raw > max_q) ? max_q : range_raw;
    if (range_clamp < min_q) begin
      range_clamp = min_q;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    ph_ticks_d = ph_ticks_q;
    rise_d     = rise_q;
    held_d     = held_q;
    update     = 1'b0;
    cleared    = 1'b0;

    if (25'(frame_q) + 25'd1 >= 25'(period_q)) begin
      frame_d = '0;
    end else begin
      frame_d = frame_q + 24'd1;
    end

    unique case (phase_q)
      PH_IDLE: begin
        if (frame_q == '0) begin
          phase_d    = PH_TRIG;
          ph_ticks_d = 24'd1;
          cleared    = 1'b1;
        end
      end
      PH_TRIG: begin
        if (ph_ticks_q >= 24'(trig_len_q)) begin
          phase_d    = PH_RISE;
          ph_ticks_d = '0;
        end else begin
          ph_ticks_d = ph_ticks_q + 24'd1;
        end
      end
      PH_RISE: begin
        if (in_i.data.echo_level) begin
          rise_d  = timer_q;
          phase_d = PH_FALL;
        end
      end
      PH_FALL: begin
        if (!in_i.data.echo_level) begin
          if (timer_q > rise_q) begin
            held_d  = range_clamp;
            update  = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            phase_d    = PH_HOLD;
            ph_ticks_d = '0;
          end
        end
      end
      PH_HOLD: begin
        ph_ticks_d = ph_ticks_q + 24'd1;
        // compare the wrapped 24-bit count
        if ((ph_ticks_q + 24'd1) >= retry_q) begin
          phase_d    = PH_TRIG;
          ph_ticks_d = 24'd1;
          cleared    = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    if (cleared) begin
      timer_d = '0;
    end else if (in_i.data.timer_advance) begin
      timer_d = timer_q + 8'd1;
    end else begin
      timer_d = timer_q;
    end

    // digit multiplex
    if (17'(dwell_q) + 17'd1 >= 17'(dwell_cfg_q)) begin
      dwell_d = '0;
      idx_d   = (idx_q == IDX_W'(DIGIT_COUNT - 1)) ? '0 : idx_q + 1'b1;
    end else begin
      dwell_d = dwell_q + 16'd1;
      idx_d   = idx_q;
    end

    sel = (4'(idx_q) < 4'd4) ? ~(4'b0001 << idx_q) : 4'hF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_len_q  <= TRIGGER_LENGTH_RST;
      retry_q     <= RETRY_HOLDOFF_RST;
      dwell_cfg_q <= DIGIT_DWELL_RST;
      period_q    <= FRAME_PERIOD_RST;
      scale_q     <= RANGE_SCALE_RST;
      min_q       <= RANGE_MINIMUM_RST;
      max_q       <= RANGE_MAXIMUM_RST;
      phase_q     <= PH_IDLE;
      ph_ticks_q  <= '0;
      timer_q     <= '0;
      rise_q      <= '0;
      held_q      <= '0;
      idx_q       <= '0;
      dwell_q     <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
      out_trig_q  <= 1'b0;
      out_sel_q   <= '0;
      out_range_q <= '0;
      out_upd_q   <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_i.data.index)
          CFG_TRIGGER_LENGTH: trig_len_q  <= cfg_i.data.value[15:0];
          CFG_RETRY_HOLDOFF:  retry_q     <= cfg_i.data.value;
          CFG_DIGIT_DWELL:    dwell_cfg_q <= cfg_i.data.value[15:0];
          CFG_FRAME_PERIOD:   period_q    <= cfg_i.data.value;
          CFG_RANGE_SCALE:    scale_q     <= cfg_i.data.value[9:0];
          CFG_RANGE_MINIMUM:  min_q       <= cfg_i.data.value[9:0];
          CFG_RANGE_MAXIMUM:  max_q       <= cfg_i.data.value[9:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_q     <= phase_d;
        ph_ticks_q  <= ph_ticks_d;
        timer_q     <= timer_d;
        rise_q      <= rise_d;
        held_q      <= held_d;
        idx_q       <= idx_d;
        dwell_q     <= dwell_d;
        frame_q     <= frame_d;
        out_valid_q <= 1'b1;
        out_trig_q  <= (phase_d == PH_TRIG);
        out_sel_q   <= sel;
        out_range_q <= held_d;
        out_upd_q   <= update;
        out_idx_q   <= idx_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // segment lookup from the registered range and digit position
  always_comb begin
    out_o.valid                = out_valid_q;
    out_o.data.trigger_out     = out_trig_q;
    out_o.data.segment_pattern = seg_decode(range_digit(out_range_q, 3'(out_idx_q)));
    out_o.data.digit_select_n  = out_sel_q;
    out_o.data.range_value     = out_range_q;
    out_o.data.range_update    = out_upd_q;
  end

  a_accept_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted tick did not produce a result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");

  a_update_above_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_upd_q) |-> (out_range_q >= min_q))
    else $error("accepted range below minimum clamp");

  a_trigger_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q != PH_TRIG && phase_d == PH_TRIG) |=> (timer_q == '0))
    else $error("echo timer not cleared at trigger start");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(DIGIT_COUNT - 1))
    else $error("digit index beyond digit count");

endmodule
